>>> rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse unit
// Element formats, control states, the divider and multiplier handshake structs and a cell index helper.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned CELLS      = 9;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned PROD_W     = 32;  // two Q8.8 elements
  localparam int unsigned DET_W      = 50;  // Q24.24 determinant, with margin
  localparam int unsigned COF_W      = 33;  // Q16.16 cofactor
  localparam int unsigned NUM_W      = 58;  // |cofactor| << 24, plus a guard bit
  localparam int unsigned QUO_W      = 58;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned DCNT_W     = 6;
  localparam int unsigned MAC_STEPS  = 16;  // bit-serial multiplier steps
  localparam int unsigned MCNT_W     = 5;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd17;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DET_MUL,
    ST_DET_MUL2,
    ST_DET_CHK,
    ST_SING_OUT,
    ST_COF_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  typedef struct packed {
    logic start;
    logic done;
  } mul_ctl_t;

  // row-major index of cell (r mod 3, c mod 3), valid for r and c below 6
  function automatic logic [3:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    logic [2:0] rr;
    logic [2:0] cc;
    rr = (r >= 3'd3) ? r - 3'd3 : r;
    cc = (c >= 3'd3) ? c - 3'd3 : c;
    return 4'(rr * 3 + cc);
  endfunction

endpackage

>>> rtl/mi3_serial_mul.sv
// ----------------------------------------------------------------------------
// mi3_serial_mul: shift-and-add multiplier
// Signed multiplicand by 16-bit signed multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mi3_serial_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [mi3_pkg::DET_W-1:0]  mcand,
  input  logic signed [mi3_pkg::ELEM_W-1:0] mplier,
  output logic                      done,
  output logic signed [mi3_pkg::DET_W-1:0]  product
);
  import mi3_pkg::*;

  logic                     busy_r, busy_nxt;
  logic [MCNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [DET_W-1:0]  acc_r, acc_nxt;
  logic signed [DET_W-1:0]  mc_r, mc_nxt;
  logic [ELEM_W-1:0]        mp_r, mp_nxt;
  logic                     done_r, done_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mc_nxt   = mcand;
      mp_nxt   = mplier;
    end else if (busy_r) begin
      // top multiplier bit carries negative weight
      if (mp_r[0]) begin
        if (cnt_r == MCNT_W'(MAC_STEPS - 1)) acc_nxt = acc_r - mc_r;
        else                                 acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + MCNT_W'(1);
      if (cnt_r == MCNT_W'(MAC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

>>> rtl/mi3_serial_div.sv
// ----------------------------------------------------------------------------
// mi3_serial_div: restoring divider with rounding and saturation
// One quotient bit a cycle; rounds to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module mi3_serial_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [mi3_pkg::COF_W-1:0] num,
  input  logic signed [mi3_pkg::DET_W-1:0] den,
  output mi3_pkg::div_ctl_t               ctl,
  output logic [mi3_pkg::VALUE_W-1:0]     quotient
);
  import mi3_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]    n_r, n_nxt;      // dividend, shifted out MSB first
  logic [DET_W:0]      rem_r, rem_nxt;
  logic [DET_W-1:0]    d_r, d_nxt;
  logic [QUO_W-1:0]    q_r, q_nxt;
  logic                neg_r, neg_nxt;
  logic [DET_W:0]      trial;
  logic [DET_W:0]      rem_sh;
  logic [COF_W-1:0]    num_mag;
  logic [DET_W-1:0]    den_mag;
  logic [QUO_W-1:0]    q_rnd;
  logic [DET_W+1:0]    rem2;

  assign num_mag = num[COF_W-1] ? COF_W'(-num) : COF_W'(num);
  assign den_mag = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
  assign rem_sh  = {rem_r[DET_W-1:0], n_r[NUM_W-1]};
  assign trial   = rem_sh - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = {1'b0, num_mag, 24'd0};
      rem_nxt  = '0;
      d_nxt    = den_mag;
      q_nxt    = '0;
      neg_nxt  = num[COF_W-1] ^ den[DET_W-1];
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (!trial[DET_W]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  // (n + d/2)/d equals floor(n/d) + (2*rem >= d) for integer d/2 rounding
  always_comb begin
    rem2  = {rem_r, 1'b0};
    q_rnd = q_r;
    if (rem2 + {1'b0, d_r[0]} > {1'b0, d_r}) q_rnd = q_r + QUO_W'(1);
    else if (rem2 >= {1'b0, d_r} && !d_r[0]) q_rnd = q_r + QUO_W'(1);
    if (neg_r) begin
      if (q_rnd > QUO_W'(64'h8000_0000)) quotient = 32'h8000_0000;
      else                               quotient = VALUE_W'(-q_rnd);
    end else begin
      if (q_rnd > QUO_W'(64'h7FFF_FFFF)) quotient = 32'h7FFF_FFFF;
      else                               quotient = VALUE_W'(q_rnd);
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

endmodule

>>> rtl/matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit: 3x3 matrix inverse by the adjugate
// Q8.8 elements in, saturated Q16.16 inverse elements out.
// ----------------------------------------------------------------------------
// Usage: send nine signed Q8.8 elements in row-major order on in_valid /
// in_stall. Elements are taken one per cycle. After the ninth, the unit
// holds in_stall high while it works: the determinant comes from six triple
// products, each built with two passes of a 16-step bit-serial multiplier,
// then each of nine cofactors takes two such multiplies and a 58-step
// restoring division. A full run's length is thus set by the serial
// multiplier and divider; a singular one ends after the determinant. A
// singular matrix (|det| below cfg_det_threshold, or zero) gives one
// transaction with out_singular and out_last set. Otherwise nine transactions
// come out, out_index 0..8, out_last on index 8. When the receiver raises
// out_stall the result is held and the unit waits. cfg_we writes the
// threshold. Synchronous reset clears control state; threshold resets to 17.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mi3_pkg::ELEM_W-1:0]   in_element,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mi3_pkg::VALUE_W-1:0]  out_value,
  output logic [mi3_pkg::INDEX_W-1:0]         out_index,
  output logic                                out_singular,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [mi3_pkg::THRESH_W-1:0]        cfg_det_threshold
);
  import mi3_pkg::*;

  state_t state_r, state_nxt;
  logic signed [ELEM_W-1:0] mat_r [CELLS];
  logic [3:0]               cnt_r, cnt_nxt;
  logic [THRESH_W-1:0]      thr_r;
  logic signed [DET_W-1:0]  det_r, det_nxt;
  logic signed [DET_W-1:0]  tmp_r, tmp_nxt;
  logic signed [COF_W-1:0]  cof_r, cof_nxt;
  logic [2:0]               term_r, term_nxt;   // determinant term 0..5
  logic [1:0]               sub_r, sub_nxt;     // cofactor product
  logic [3:0]               k_r, k_nxt;
  logic signed [VALUE_W-1:0] oval_r;
  logic [INDEX_W-1:0]       oidx_r;
  logic                     osing_r, olast_r, ovalid_r;
  logic                     load_out, in_acc, out_acc;

  logic                     mul_start_r, mul_start_nxt;
  logic                     mul_done;
  logic signed [DET_W-1:0]  mcand;
  logic signed [ELEM_W-1:0] mplier;
  logic signed [DET_W-1:0]  product;
  div_ctl_t                 div_st;
  logic                     div_start;
  logic [VALUE_W-1:0]       quot;
  logic [DET_W-1:0]         det_mag;
  logic [3:0]               ia, ib, ic;
  logic [3:0]               i, j;

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ovalid_r && !out_stall;

  // three cells of determinant term; first three add, last three subtract
  always_comb begin
    unique case (term_r)
      3'd0:    begin ia = cell_idx(3'd0, 3'd0); ib = cell_idx(3'd1, 3'd1); ic = cell_idx(3'd2, 3'd2); end
      3'd1:    begin ia = cell_idx(3'd1, 3'd0); ib = cell_idx(3'd2, 3'd1); ic = cell_idx(3'd0, 3'd2); end
      3'd2:    begin ia = cell_idx(3'd2, 3'd0); ib = cell_idx(3'd0, 3'd1); ic = cell_idx(3'd1, 3'd2); end
      3'd3:    begin ia = cell_idx(3'd0, 3'd2); ib = cell_idx(3'd1, 3'd1); ic = cell_idx(3'd2, 3'd0); end
      3'd4:    begin ia = cell_idx(3'd1, 3'd2); ib = cell_idx(3'd2, 3'd1); ic = cell_idx(3'd0, 3'd0); end
      default: begin ia = cell_idx(3'd2, 3'd2); ib = cell_idx(3'd0, 3'd1); ic = cell_idx(3'd1, 3'd0); end
    endcase
  end

  // k = i*3 + j
  always_comb begin
    i = (k_r >= 4'd6) ? 4'd2 : (k_r >= 4'd3) ? 4'd1 : 4'd0;
    j = k_r - 4'(i * 3);
  end

  // multiplier operands per state; launch is on entry or on sub_r change
  always_comb begin
    mcand  = '0;
    mplier = '0;
    unique case (state_r)
      ST_DET_MUL:  begin mcand = DET_W'(mat_r[ia]); mplier = mat_r[ib]; end
      ST_DET_MUL2: begin mcand = tmp_r;             mplier = mat_r[ic]; end
      ST_COF_MUL: begin
        if (sub_r == 2'd0) begin
          mcand  = DET_W'(mat_r[cell_idx(3'(j + 1), 3'(i + 1))]);
          mplier = mat_r[cell_idx(3'(j + 2), 3'(i + 2))];
        end else begin
          mcand  = DET_W'(mat_r[cell_idx(3'(j + 1), 3'(i + 2))]);
          mplier = mat_r[cell_idx(3'(j + 2), 3'(i + 1))];
        end
      end
      default: ;
    endcase
  end

  mi3_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  mi3_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (cof_r),
    .den      (det_r),
    .ctl      (div_st),
    .quotient (quot)
  );

  assign det_mag = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_acc && cnt_r == 4'(CELLS - 1)) state_nxt = ST_DET_MUL;
      ST_DET_MUL:   if (mul_done) state_nxt = ST_DET_MUL2;
      ST_DET_MUL2:  if (mul_done) state_nxt = (term_r == 3'd5) ? ST_DET_CHK : ST_DET_MUL;
      ST_DET_CHK:
        if (!ovalid_r || out_acc) begin
          if (det_r == '0 || det_mag < DET_W'(thr_r)) state_nxt = ST_SING_OUT;
          else                                        state_nxt = ST_COF_MUL;
        end
      ST_SING_OUT:  state_nxt = ST_LOAD;
      ST_COF_MUL:   if (mul_done && sub_r == 2'd1) state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_st.done) state_nxt = ST_OUT;
      ST_OUT:
        if (!ovalid_r || out_acc) state_nxt = (k_r == 4'(CELLS - 1)) ? ST_LOAD : ST_COF_MUL;
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    mul_start_nxt = 1'b0;
    div_start     = (state_r == ST_DIV_START);
    load_out      = 1'b0;
    unique case (state_r)
      ST_LOAD:     mul_start_nxt = in_acc && cnt_r == 4'(CELLS - 1);
      ST_DET_MUL:  mul_start_nxt = mul_done;
      ST_DET_MUL2: mul_start_nxt = mul_done && term_r != 3'd5;
      ST_DET_CHK:
        mul_start_nxt = (!ovalid_r || out_acc) && !(det_r == '0 || det_mag < DET_W'(thr_r));
      ST_COF_MUL:  mul_start_nxt = mul_done && sub_r == 2'd0;
      ST_OUT: begin
        load_out      = !ovalid_r || out_acc;
        mul_start_nxt = load_out && k_r != 4'(CELLS - 1);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt  = cnt_r;
    det_nxt  = det_r;
    tmp_nxt  = tmp_r;
    cof_nxt  = cof_r;
    term_nxt = term_r;
    sub_nxt  = sub_r;
    k_nxt    = k_r;
    if (state_r == ST_LOAD && in_acc) begin
      cnt_nxt  = (cnt_r == 4'(CELLS - 1)) ? 4'd0 : cnt_r + 4'd1;
      det_nxt  = '0;
      term_nxt = '0;
    end
    if (state_r == ST_DET_MUL && mul_done) tmp_nxt = product;
    if (state_r == ST_DET_MUL2 && mul_done) begin
      det_nxt  = (term_r < 3'd3) ? det_r + product : det_r - product;
      term_nxt = term_r + 3'd1;
    end
    if (state_r == ST_DET_CHK) begin
      k_nxt   = '0;
      sub_nxt = '0;
    end
    if (state_r == ST_COF_MUL && mul_done) begin
      if (sub_r == 2'd0) begin
        cof_nxt = COF_W'(product);
        sub_nxt = 2'd1;
      end else begin
        cof_nxt = cof_r - COF_W'(product);
        sub_nxt = 2'd0;
      end
    end
    if (load_out) k_nxt = k_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      thr_r       <= THRESH_RESET;
      ovalid_r    <= 1'b0;
      term_r      <= '0;
      sub_r       <= '0;
      k_r         <= '0;
      mul_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      sub_r       <= sub_nxt;
      k_r         <= k_nxt;
      mul_start_r <= mul_start_nxt;
      if (cfg_we) thr_r <= cfg_det_threshold;
      if (state_r == ST_SING_OUT || load_out) ovalid_r <= 1'b1;
      else if (out_acc)                       ovalid_r <= 1'b0;
    end
    det_r <= det_nxt;
    tmp_r <= tmp_nxt;
    cof_r <= cof_nxt;
    if (state_r == ST_LOAD && in_acc) mat_r[cnt_r] <= in_element;
    if (state_r == ST_SING_OUT) begin
      oval_r  <= '0;
      oidx_r  <= '0;
      osing_r <= 1'b1;
      olast_r <= 1'b1;
    end else if (load_out) begin
      oval_r  <= quot;
      oidx_r  <= k_r;
      osing_r <= 1'b0;
      olast_r <= (k_r == 4'(CELLS - 1));
    end
  end

  assign out_valid    = ovalid_r;
  assign out_value    = oval_r;
  assign out_index    = oidx_r;
  assign out_singular = osing_r;
  assign out_last     = olast_r;

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_index))
    else $error("result changed while stalled");
  // no input taken while computing
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> in_stall)
    else $error("input accepted during compute");
  // singular result is always last
  a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last)
    else $error("singular result not last");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index <= 4'(CELLS - 1))
    else $error("result index out of range");

endmodule
